// ===== design/ptp_pkg.sv =====
// Shared widths, register and mode codes, and the color word type for the texture evaluator.
package ptp_pkg;

  localparam int COORD_W    = 32;
  localparam int CHAN_W     = 16;
  localparam int COLOR_W    = 3 * CHAN_W;
  localparam int SUM_W      = 2 * COORD_W;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COLOR_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_STRIPE   = 3'd0,
    MODE_GRADIENT = 3'd1,
    MODE_RING     = 3'd2,
    MODE_CHECKER  = 3'd3,
    MODE_RADIAL   = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_FIRST  = 2'd1,
    CFG_SECOND = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

endpackage

// ===== design/ptp_prep.sv =====
// Front stages: absolute coordinates, parity and fraction taps, squares, sum of squares.
module ptp_prep #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          vld_i,
  input  logic [ptp_pkg::COORD_W-1:0]   x_i,
  input  logic [ptp_pkg::COORD_W-1:0]   y_i,
  input  logic [ptp_pkg::COORD_W-1:0]   z_i,
  input  logic [ptp_pkg::MODE_W-1:0]    mode_i,
  output logic                          vld_o,
  output logic [ptp_pkg::SUM_W-1:0]     sum_o,
  output logic                          pick_o,
  output logic [COORD_FRAC_BITS-1:0]    frac_o
);
  import ptp_pkg::*;

  logic [COORD_W-1:0]         ax_d, ay_d, az_d;
  logic [COORD_W-1:0]         ax_q, ay_q, az_q;
  logic                       pick_d;
  logic                       pick1_q, pick2_q, pick3_q;
  logic [COORD_FRAC_BITS-1:0] frac1_q, frac2_q, frac3_q;
  logic [SUM_W-1:0]           sqx_q, sqy_q, sqz_q, sum_q;
  logic                       vld1_q, vld2_q, vld3_q;

  // y only counts toward the radial distance
  always_comb begin
    ax_d = x_i[COORD_W-1] ? (~x_i + 1'b1) : x_i;
    az_d = z_i[COORD_W-1] ? (~z_i + 1'b1) : z_i;
    if (mode_i == MODE_RADIAL) begin
      ay_d = y_i[COORD_W-1] ? (~y_i + 1'b1) : y_i;
    end else begin
      ay_d = '0;
    end
    unique case (mode_i)
      MODE_STRIPE:  pick_d = x_i[COORD_FRAC_BITS];
      MODE_CHECKER: pick_d = x_i[COORD_FRAC_BITS] ^ y_i[COORD_FRAC_BITS] ^ z_i[COORD_FRAC_BITS];
      default:      pick_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ax_q    <= ax_d;
      ay_q    <= ay_d;
      az_q    <= az_d;
      pick1_q <= pick_d;
      frac1_q <= x_i[COORD_FRAC_BITS-1:0];
      sqx_q   <= SUM_W'(ax_q) * SUM_W'(ax_q);
      sqy_q   <= SUM_W'(ay_q) * SUM_W'(ay_q);
      sqz_q   <= SUM_W'(az_q) * SUM_W'(az_q);
      pick2_q <= pick1_q;
      frac2_q <= frac1_q;
      sum_q   <= sqx_q + sqy_q + sqz_q;
      pick3_q <= pick2_q;
      frac3_q <= frac2_q;
    end
  end

  assign vld_o  = vld3_q;
  assign sum_o  = sum_q;
  assign pick_o = pick3_q;
  assign frac_o = frac3_q;

endmodule

// ===== design/ptp_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a sideband tag.
module ptp_sqrt #(
  parameter int TAG_W = 17
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        vld_i,
  input  logic [ptp_pkg::SUM_W-1:0]   rad_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        vld_o,
  output logic [ptp_pkg::ROOT_W-1:0]  root_o,
  output logic [TAG_W-1:0]            tag_o
);
  import ptp_pkg::*;

  localparam int STAGES = ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  logic                vld_q  [STAGES];
  logic [REM_W-1:0]    rem_q  [STAGES];
  logic [ROOT_W-1:0]   root_q [STAGES];
  logic [SUM_W-1:0]    rad_q  [STAGES];
  logic [TAG_W-1:0]    tag_q  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic              vld_in;
    logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_nx;
    logic [ROOT_W-1:0] root_in, root_nx;
    logic [SUM_W-1:0]  rad_in;
    logic [TAG_W-1:0]  tag_in;
    logic              fits;

    if (k == 0) begin : g_head
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign tag_in  = tag_i;
    end else begin : g_body
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
      rem_sh  = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
      trial   = REM_W'({root_in, 2'b01});
      fits    = rem_sh >= trial;
      rem_nx  = fits ? (rem_sh - trial) : rem_sh;
      root_nx = {root_in[ROOT_W-2:0], fits};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= rem_nx;
        root_q[k] <= root_nx;
        rad_q[k]  <= {rad_in[SUM_W-3:0], 2'b00};
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign vld_o  = vld_q[STAGES-1];
  assign root_o = root_q[STAGES-1];
  assign tag_o  = tag_q[STAGES-1];

endmodule

// ===== design/ptp_blend.sv =====
// Back stages: color pick or per-channel interpolation with round half up.
module ptp_blend #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int CHANNEL_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         vld_i,
  input  logic [ptp_pkg::ROOT_W-1:0]   root_i,
  input  logic                         pick_i,
  input  logic [COORD_FRAC_BITS-1:0]   frac_i,
  input  logic [ptp_pkg::MODE_W-1:0]   mode_i,
  input  logic [ptp_pkg::COLOR_W-1:0]  first_i,
  input  logic [ptp_pkg::COLOR_W-1:0]  second_i,
  output logic                         vld_o,
  output ptp_pkg::rgb_t                rgb_o
);
  import ptp_pkg::*;

  localparam int F      = COORD_FRAC_BITS;
  localparam int CB     = CHANNEL_BITS;
  localparam int PROD_W = CB + F + 2;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(2 ** (F - 1));

  logic [F-1:0]      frac_sel;
  logic              odd;
  logic              lerp_d, lerp_q;
  logic              vld1_q, vld2_q;
  logic [CHAN_W-1:0] chan_out [3];
  rgb_t              rgb_q;

  always_comb begin
    frac_sel = (mode_i == MODE_GRADIENT) ? frac_i : root_i[F-1:0];
    lerp_d   = (mode_i == MODE_GRADIENT) || (mode_i == MODE_RADIAL);
    unique case (mode_i)
      MODE_STRIPE, MODE_CHECKER: odd = pick_i;
      MODE_RING:                 odd = root_i[F];
      default:                   odd = 1'b0;
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_chan
    localparam int LSB = COLOR_W - CHAN_W * (k + 1);
    logic [CB-1:0]            a, b;
    logic signed [CB:0]       diff;
    logic signed [F:0]        fs;
    logic [CB-1:0]            a_q, pc_q;
    logic signed [PROD_W-1:0] prod_q, shf, sum;

    always_comb begin
      a    = first_i[LSB +: CB];
      b    = second_i[LSB +: CB];
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      fs   = $signed({1'b0, frac_sel});
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        a_q    <= a;
        pc_q   <= odd ? b : a;
        prod_q <= PROD_W'(diff) * PROD_W'(fs);
      end
    end

    // floor of (prod + half) / 2^F, added back onto the start color
    always_comb begin
      shf = (prod_q + HALF) >>> F;
      sum = PROD_W'($signed({1'b0, a_q})) + shf;
    end

    assign chan_out[k] = lerp_q ? CHAN_W'(sum[CB-1:0]) : CHAN_W'(pc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lerp_q      <= lerp_d;
      rgb_q.red   <= chan_out[0];
      rgb_q.green <= chan_out[1];
      rgb_q.blue  <= chan_out[2];
    end
  end

  assign vld_o = vld2_q;
  assign rgb_o = rgb_q;

endmodule

// ===== design/procedural_texture_pattern_eval.sv =====
// Top level of the procedural texture evaluator: config registers, pipeline, output skid.
//
//   channel   direction  handshake               word
//   --------  ---------  ----------------------  ------------------------------
//   point     in         in_valid_i/in_ready_o   point_x_i, point_y_i, point_z_i
//   color     out        out_valid_o/out_ready_i red_o, green_o, blue_o
//   config    in         cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// One word enters per clock while in_ready_o is high. A word passes 3 front,
// 32 square-root and 2 blend stages, the first loaded at the accepting edge;
// the skid buffer then registers the blend output before offering it.
// The square-root pipeline, one root bit per stage, sets the depth. Reset clears
// the config registers, all valid bits and the skid count. The whole pipeline
// holds while the two-entry skid buffer is full, so in_ready_o depends on registers only.
module procedural_texture_pattern_eval #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int CHANNEL_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ptp_pkg::COORD_W-1:0]     point_x_i,
  input  logic [ptp_pkg::COORD_W-1:0]     point_y_i,
  input  logic [ptp_pkg::COORD_W-1:0]     point_z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ptp_pkg::CHAN_W-1:0]      red_o,
  output logic [ptp_pkg::CHAN_W-1:0]      green_o,
  output logic [ptp_pkg::CHAN_W-1:0]      blue_o
);
  import ptp_pkg::*;

  localparam int F     = COORD_FRAC_BITS;
  localparam int TAG_W = F + 1;

  // Configuration registers
  logic [MODE_W-1:0]  mode_q;
  logic [COLOR_W-1:0] first_q, second_q;

  // Pipeline wiring
  logic               adv;
  logic               prep_vld, sqrt_vld, blend_vld;
  logic [SUM_W-1:0]   prep_sum;
  logic               prep_pick;
  logic [F-1:0]       prep_frac;
  logic [TAG_W-1:0]   sqrt_tag;
  logic [ROOT_W-1:0]  sqrt_root;
  rgb_t               blend_rgb;

  // Output skid buffer
  logic [1:0]         cnt_q, cnt_d;
  rgb_t               ent0_q, ent1_q;
  logic               push, pop;

  // Write the addressed register; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_FIRST:  first_q  <= cfg_data_i[COLOR_W-1:0];
        CFG_SECOND: second_q <= cfg_data_i[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance every stage unless the skid buffer is full.
  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  ptp_prep #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (in_valid_i),
    .x_i    (point_x_i),
    .y_i    (point_y_i),
    .z_i    (point_z_i),
    .mode_i (mode_q),
    .vld_o  (prep_vld),
    .sum_o  (prep_sum),
    .pick_o (prep_pick),
    .frac_o (prep_frac)
  );

  // The ring index is the root of x^2+z^2 shifted down by F, so ring and
  // radial modes share one root: bit F gives the ring parity, the low F bits
  // give the radial fraction.
  ptp_sqrt #(
    .TAG_W(TAG_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (prep_vld),
    .rad_i  (prep_sum),
    .tag_i  ({prep_pick, prep_frac}),
    .vld_o  (sqrt_vld),
    .root_o (sqrt_root),
    .tag_o  (sqrt_tag)
  );

  ptp_blend #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .CHANNEL_BITS   (CHANNEL_BITS)
  ) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .vld_i    (sqrt_vld),
    .root_i   (sqrt_root),
    .pick_i   (sqrt_tag[TAG_W-1]),
    .frac_i   (sqrt_tag[F-1:0]),
    .mode_i   (mode_q),
    .first_i  (first_q),
    .second_i (second_q),
    .vld_o    (blend_vld),
    .rgb_o    (blend_rgb)
  );

  // Skid buffer: entry 0 drives the output, entry 1 catches a word that
  // arrives while entry 0 waits.
  assign push = blend_vld && adv;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      // drop the head; the new word or the waiting one moves up
      if (cnt_q == 2'd2) begin
        ent0_q <= ent1_q;
      end else if (push) begin
        ent0_q <= blend_rgb;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        ent0_q <= blend_rgb;
      end else begin
        ent1_q <= blend_rgb;
      end
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign red_o       = ent0_q.red;
  assign green_o     = ent0_q.green;
  assign blue_o      = ent0_q.blue;

  // A full skid buffer always has a word on offer.
  a_full_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input held while no word is offered");

  // Count follows one push without a pop.
  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("skid count missed a push");

  // A stalled pipeline keeps its last word.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && blend_vld) |=> (blend_vld && $stable(blend_rgb)))
    else $error("pipeline word changed during a stall");

endmodule
